[src/rsel_pkg.sv]
package rsel_pkg;

	// Field widths of the words on the ports
	localparam int VALUE_W = 32;
	localparam int POS_W   = 16;
	localparam int KEEP_W  = 6;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_KEEP    = 32;
	localparam int DEF_MAX_ROW_LEN = 65536;

	// Reset value of the keep count register
	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(32);

	// Contents of an empty slot
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [POS_W-1:0] POS_EMPTY = '1;

	// One kept entry
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		logic                      valid;
	} entry_t;

	localparam entry_t ENTRY_CLEAR = '{value: VALUE_MAX, pos: '0, valid: 1'b0};

	// Operation applied to every cell of the row alike
	typedef struct packed {
		logic insert;
		logic emit;
		logic clear;
	} cell_ctrl_t;

endpackage

[src/rsel_cell.sv]
module rsel_cell
	import rsel_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       en,
	input  entry_t     new_ent,
	input  entry_t     prev_ent,
	input  entry_t     next_ent,
	input  logic       hit_in,
	output logic       hit_out,
	output entry_t     ent
);

	entry_t ent_q;
	logic   take;

	// Slot takes the new word when empty or holding a strictly larger value
	assign take    = !ent_q.valid || (ent_q.value > new_ent.value);
	assign hit_out = hit_in || (en && take);
	assign ent     = ent_q;

	// Hold, take the new word, shift down on insert, shift up on emit, or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= ENTRY_CLEAR;
		end else if (ctrl.clear) begin
			ent_q <= ENTRY_CLEAR;
		end else if (ctrl.emit) begin
			ent_q <= next_ent;
		end else if (ctrl.insert && en) begin
			if (hit_in) begin
				ent_q <= prev_ent;
			end else if (take) begin
				ent_q <= new_ent;
			end
		end
	end

endmodule

[src/row_k_smallest_selector_core.sv]
// Keeps the keep_count smallest values of a row in a row of compare-and-shift
// cells, sorted ascending, earlier position first among equal values. A
// non-final element is inserted as it is accepted, so a row streams in at
// one word per clock outside emission runs. An element marked row_end is
// inserted in its accept cycle; the block then stalls its input while it
// shifts the k kept entries out through the output register, one word per
// cycle when the output is not stalled. The position count is cleared as
// the row_end word is accepted, the list and overflow flag as the last word
// of the run is loaded. Empty slots come out with the largest value, position
// all ones and slot_filled low. keep_count is written through the cfg channel
// (always ready); 0 acts as 1 and values above MAX_KEEP act as MAX_KEEP.
module row_k_smallest_selector_core
	import rsel_pkg::*;
#(
	parameter int MAX_KEEP    = DEF_MAX_KEEP,
	parameter int MAX_ROW_LEN = DEF_MAX_ROW_LEN
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [KEEP_W-1:0]         cfg_data,
	// input words
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] sample_value,
	input  logic                      row_end,
	// result words
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] best_value,
	output logic [POS_W-1:0]          best_position,
	output logic                      slot_filled,
	output logic                      run_end,
	output logic                      row_overflow
);

	localparam int KW        = $clog2(MAX_KEEP + 1);
	localparam int POS_LIMIT = (MAX_ROW_LEN - 1 > 65535) ? 65535 : MAX_ROW_LEN - 1;
	localparam int CNT_W     = $clog2(POS_LIMIT + 2);

	logic [KEEP_W-1:0] keep_q;
	logic [KW-1:0]     k_eff;
	logic [CNT_W-1:0]  pos_cnt_q;
	logic              ovf_q;
	logic              emit_q;
	logic [KW-1:0]     ecnt_q;
	logic              out_valid_q;

	logic              in_acc;
	logic              out_load;
	logic              emit_last;
	logic              saturate;
	entry_t            new_ent;
	cell_ctrl_t        ctrl;

	entry_t            chain [MAX_KEEP];
	logic              hit   [MAX_KEEP+1];

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			keep_q <= cfg_data;
		end
	end

	// Effective keep count, clamped to 1..MAX_KEEP
	always_comb begin
		if (keep_q == '0) begin
			k_eff = KW'(1);
		end else if (int'(keep_q) > MAX_KEEP) begin
			k_eff = KW'(MAX_KEEP);
		end else begin
			k_eff = KW'(keep_q);
		end
	end

	// Handshakes
	assign in_stall  = emit_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = emit_q && (!out_valid_q || !out_stall);
	assign emit_last = (ecnt_q == KW'(k_eff - KW'(1)));

	// Position of the incoming word, saturating at the limit
	assign saturate      = (pos_cnt_q > CNT_W'(POS_LIMIT));
	assign new_ent.value = sample_value;
	assign new_ent.pos   = saturate ? POS_W'(POS_LIMIT) : POS_W'(pos_cnt_q);
	assign new_ent.valid = 1'b1;

	assign ctrl.insert = in_acc;
	assign ctrl.emit   = out_load;
	assign ctrl.clear  = out_load && emit_last;

	// Row of cells: hit ripples down, entries shift down on insert, up on emit
	assign hit[0] = 1'b0;

	for (genvar j = 0; j < MAX_KEEP; j++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;

		if (j == 0) begin : g_first
			assign prev_e = ENTRY_CLEAR;
		end else begin : g_mid
			assign prev_e = chain[j-1];
		end

		if (j == MAX_KEEP - 1) begin : g_last
			assign next_e = ENTRY_CLEAR;
		end else begin : g_inner
			assign next_e = chain[j+1];
		end

		rsel_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.en       (KW'(j) < k_eff),
			.new_ent  (new_ent),
			.prev_ent (prev_e),
			.next_ent (next_e),
			.hit_in   (hit[j]),
			.hit_out  (hit[j+1]),
			.ent      (chain[j])
		);
	end

	// Row bookkeeping and emission sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q <= '0;
			ovf_q     <= 1'b0;
			emit_q    <= 1'b0;
			ecnt_q    <= '0;
		end else begin
			if (in_acc) begin
				if (row_end) begin
					pos_cnt_q <= '0;
					emit_q    <= 1'b1;
					ecnt_q    <= '0;
				end else if (!saturate) begin
					pos_cnt_q <= pos_cnt_q + CNT_W'(1);
				end
				if (saturate) begin
					ovf_q <= 1'b1;
				end
			end
			if (out_load) begin
				if (emit_last) begin
					emit_q <= 1'b0;
					ovf_q  <= 1'b0;
				end else begin
					ecnt_q <= ecnt_q + KW'(1);
				end
			end
		end
	end

	// Output register, loaded from the head cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			best_value    <= chain[0].valid ? chain[0].value : VALUE_MAX;
			best_position <= chain[0].valid ? chain[0].pos : POS_EMPTY;
			slot_filled   <= chain[0].valid;
			run_end       <= emit_last;
			row_overflow  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// A row end word starts an emission run
	a_row_end_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && row_end) |=> (emit_q && ecnt_q == '0))
		else $error("row end did not start emission");

	// The last word of a run ends emission and clears the head cell
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_last) |=> (!emit_q && !chain[0].valid && pos_cnt_q == '0))
		else $error("emission did not end cleanly");

	// The run_end word is the one that closes emission
	a_run_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !emit_last) |=> emit_q)
		else $error("emission stopped before run end");
`endif

endmodule

[test/tb.sv]
module tb;
	import rsel_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int POS_LIMIT     = (DEF_MAX_ROW_LEN - 1 > 65535) ? 65535 : DEF_MAX_ROW_LEN - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		logic                      filled;
		logic                      last;
		logic                      ovf;
	} best_t;

	typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE} val_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [KEEP_W-1:0]         cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] sample_value = '0;
	logic                      row_end = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] best_value;
	logic [POS_W-1:0]          best_position;
	logic                      slot_filled;
	logic                      run_end;
	logic                      row_overflow;

	// Shadow copy of the sorted list and the row bookkeeping
	logic signed [VALUE_W-1:0] list_value [DEF_MAX_KEEP];
	logic [POS_W-1:0]          list_pos [DEF_MAX_KEEP];
	logic                      list_full [DEF_MAX_KEEP];
	int unsigned               row_index;
	logic                      row_ovf;
	logic [KEEP_W-1:0]         keep_setting;

	best_t pending_best[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;
	int failures = 0;
	int words_in = 0;
	int results_out = 0;
	int rows_done = 0;

	row_k_smallest_selector_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.row_end      (row_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.best_value   (best_value),
		.best_position(best_position),
		.slot_filled  (slot_filled),
		.run_end      (run_end),
		.row_overflow (row_overflow)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Give up on a hung run
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// Stall the result side: long hold-off first, else random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	function automatic int keep_eff();
		if (keep_setting == 0)
			return 1;
		if (keep_setting > DEF_MAX_KEEP)
			return DEF_MAX_KEEP;
		return int'(keep_setting);
	endfunction

	function automatic void clear_list();
		for (int j = 0; j < DEF_MAX_KEEP; j++) begin
			list_value[j] = VALUE_MAX;
			list_pos[j]   = '0;
			list_full[j]  = 1'b0;
		end
		row_index = 0;
		row_ovf   = 1'b0;
	endfunction

	// Insert one element into the sorted list; on row end queue the k best
	function automatic void predict_word(logic signed [VALUE_W-1:0] v, logic last);
		int k;
		int slot;
		logic [POS_W-1:0] p;
		best_t r;
		k = keep_eff();
		if (row_index > POS_LIMIT) begin
			p       = POS_W'(POS_LIMIT);
			row_ovf = 1'b1;
		end else begin
			p = POS_W'(row_index);
			row_index++;
		end
		// first slot that is empty or strictly larger wins
		slot = k;
		for (int j = k - 1; j >= 0; j--)
			if (!list_full[j] || list_value[j] > v)
				slot = j;
		if (slot < k) begin
			for (int j = k - 1; j > slot; j--) begin
				list_value[j] = list_value[j-1];
				list_pos[j]   = list_pos[j-1];
				list_full[j]  = list_full[j-1];
			end
			list_value[slot] = v;
			list_pos[slot]   = p;
			list_full[slot]  = 1'b1;
		end
		if (last) begin
			for (int j = 0; j < k; j++) begin
				r.value  = list_full[j] ? list_value[j] : VALUE_MAX;
				r.pos    = list_full[j] ? list_pos[j] : POS_EMPTY;
				r.filled = list_full[j];
				r.last   = (j == k - 1);
				r.ovf    = row_ovf;
				pending_best.push_back(r);
			end
			clear_list();
			rows_done++;
		end
	endfunction

	// Track config and input handshakes, check every result word
	always @(posedge clk) begin : monitor
		best_t got;
		best_t want;
		if (cfg_valid && cfg_ready)
			keep_setting = cfg_data;
		if (in_valid && !in_stall) begin
			predict_word(sample_value, row_end);
			words_in++;
		end
		if (out_valid && !out_stall) begin
			got = '{value: best_value, pos: best_position, filled: slot_filled,
				last: run_end, ovf: row_overflow};
			results_out++;
			if (pending_best.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected result: value %0d pos %0d filled %0b end %0b ovf %0b",
						got.value, got.pos, got.filled, got.last, got.ovf);
			end else begin
				want = pending_best.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= REPORT_MAX)
						$display({"mismatch: expected value %0d pos %0d filled %0b end %0b ovf %0b,",
							" got value %0d pos %0d filled %0b end %0b ovf %0b"},
							want.value, want.pos, want.filled, want.last, want.ovf,
							got.value, got.pos, got.filled, got.last, got.ovf);
				end
			end
		end
	end

	// Offer one word, with random gaps before it, and wait until taken
	task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= v;
		row_end      <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid, wait for all results, then let the block settle
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		// let the monitor account for the last accepted word first
		@(posedge clk);
		while (pending_best.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_best.size() != 0) begin
			failures++;
			if (failures <= REPORT_MAX)
				$display("%0d expected result words never arrived", pending_best.size());
			pending_best.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KEEP_W-1:0] k);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idle(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value(val_mode_t mode);
		case (mode)
			VAL_NARROW: return int'($urandom_range(6)) - 3;
			VAL_EDGE: begin
				case ($urandom_range(3))
					0: return VALUE_MAX;
					1: return ~VALUE_MAX;
					2: return '1;
					default: return '0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEEP_W-1:0] pick_keep();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return KEEP_W'(DEF_MAX_KEEP);
			3: return KEEP_W'(DEF_MAX_KEEP + 1);
			default: return KEEP_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Reset keep count: few elements, most slots empty, extremes of the value
	task automatic test_default_keep();
		send_word(VALUE_MAX, 1'b0);
		send_word(~VALUE_MAX, 1'b0);
		send_word('0, 1'b1);
	endtask

	// Equal values keep arrival order, the tail slot falls off
	task automatic test_ties();
		write_keep(KEEP_W'(4));
		send_word(5, 1'b0);
		send_word(5, 1'b0);
		send_word(-1, 1'b0);
		send_word(5, 1'b0);
		send_word(5, 1'b0);
		send_word(5, 1'b1);
	endtask

	// One kept slot, a one-word row, and a zero keep count acting as one
	task automatic test_small_keep();
		write_keep(KEEP_W'(1));
		send_word(7, 1'b1);
		write_keep('0);
		send_word(3, 1'b0);
		send_word(-8, 1'b0);
		send_word(2, 1'b1);
	endtask

	// Keep counts above the list size act as the full list
	task automatic test_keep_clamp();
		write_keep('1);
		send_word(1, 1'b0);
		send_word(0, 1'b1);
		write_keep(KEEP_W'(DEF_MAX_KEEP + 1));
		send_word(-2, 1'b1);
	endtask

	// Hold the result side off while rows keep coming, so the input stalls
	task automatic test_backpressure();
		write_keep(KEEP_W'(DEF_MAX_KEEP));
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		for (int r = 0; r < 4; r++)
			for (int i = 0; i < 8; i++)
				send_word($urandom, i == 7);
	endtask

	// Random rows in blocks, a new keep count before each block
	task automatic test_random(input int n_words);
		int sent;
		int blk;
		int len;
		val_mode_t mode;
		sent = 0;
		while (sent < n_words) begin
			write_keep(pick_keep());
			blk = 0;
			while (blk < 40 && sent < n_words) begin
				len  = ($urandom_range(9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
				mode = val_mode_t'($urandom_range(2));
				for (int i = 0; i < len; i++)
					send_word(pick_value(mode), i == len - 1);
				blk  += len;
				sent += len;
			end
		end
	endtask

	initial begin
		keep_setting = KEEP_RESET;
		clear_list();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(8, 85);
		test_default_keep();
		test_ties();
		test_small_keep();
		test_keep_clamp();
		test_random(145);

		set_idle(85, 8);
		test_random(145);

		set_idle(0, 0);
		test_backpressure();
		test_random(145);

		drain();
		$display("Ran %0d rows, %0d input words and %0d result words", rows_done, words_in,
			results_out);
		$display("Keep counts 0 to 63, ties, empty slots, edge values and output hold-off");
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
